[sv/ftfe_pkg.sv]
// types, constants and tag decode functions for the fcp tlv field extractor
// no dependencies
`timescale 1ns / 1ps

package ftfe_pkg;

    typedef enum logic [2:0] {
        PH_TAG = 3'b001,
        PH_LEN = 3'b010,
        PH_VAL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_last;
    } in_t;

    typedef struct packed {
        logic       emit;
        logic [3:0] field_code;
        logic [7:0] byte_index;
        logic [7:0] value_byte;
        logic       value_end;
        logic       key_file;
        logic       frame_end;
        logic       truncated;
    } out_t;

    typedef struct packed {
        logic       nested_level;
        phase_t     outer_phase;
        phase_t     inner_phase;
        logic [7:0] outer_tag;
        logic [7:0] outer_remaining;
        logic [7:0] inner_tag;
        logic [7:0] inner_remaining;
        logic [7:0] container_remaining;
        logic [7:0] value_position;
        logic       key_file_flag;
    } state_t;

    localparam state_t STATE_RESET = '{
        nested_level:        1'b0,
        outer_phase:         PH_TAG,
        inner_phase:         PH_TAG,
        outer_tag:           8'h00,
        outer_remaining:     8'h00,
        inner_tag:           8'h00,
        inner_remaining:     8'h00,
        container_remaining: 8'h00,
        value_position:      8'h00,
        key_file_flag:       1'b0
    };

    localparam logic [7:0] TAG_TEMPLATE  = 8'h62;
    localparam logic [7:0] TAG_CONTAINER = 8'hA5;
    localparam logic [7:0] TAG_FILE_TYPE = 8'h82;
    localparam logic [7:0] FT_KEY_A      = 8'h11;
    localparam logic [7:0] FT_KEY_B      = 8'h51;

    localparam logic [3:0] CODE_O80  = 4'd0;
    localparam logic [3:0] CODE_O82  = 4'd1;
    localparam logic [3:0] CODE_O83  = 4'd2;
    localparam logic [3:0] CODE_O84  = 4'd3;
    localparam logic [3:0] CODE_O88  = 4'd4;
    localparam logic [3:0] CODE_O8A  = 4'd5;
    localparam logic [3:0] CODE_O8B  = 4'd6;
    localparam logic [3:0] CODE_K85  = 4'd7;
    localparam logic [3:0] CODE_K86  = 4'd8;
    localparam logic [3:0] CODE_K87  = 4'd9;
    localparam logic [3:0] CODE_K89  = 4'd10;
    localparam logic [3:0] CODE_K8B  = 4'd11;
    localparam logic [3:0] CODE_K8E  = 4'd12;
    localparam logic [3:0] CODE_N81  = 4'd13;
    localparam logic [3:0] NO_CODE   = 4'd15;

    function automatic logic [3:0] outer_code(input logic [7:0] t);
        logic [3:0] c;
        unique case (t)
            8'h80:   c = CODE_O80;
            8'h82:   c = CODE_O82;
            8'h83:   c = CODE_O83;
            8'h84:   c = CODE_O84;
            8'h88:   c = CODE_O88;
            8'h8A:   c = CODE_O8A;
            8'h8B:   c = CODE_O8B;
            default: c = NO_CODE;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] inner_code(input logic [7:0] t, input logic key);
        logic [3:0] c;
        if (!key)
        begin
            c = (t == 8'h81) ? CODE_N81 : NO_CODE;
        end
        else
        begin
            unique case (t)
                8'h85:   c = CODE_K85;
                8'h86:   c = CODE_K86;
                8'h87:   c = CODE_K87;
                8'h89:   c = CODE_K89;
                8'h8B:   c = CODE_K8B;
                8'h8E:   c = CODE_K8E;
                default: c = NO_CODE;
            endcase
        end
        return c;
    endfunction

endpackage

[sv/ftfe_step.sv]
// next-state and result logic for one byte of the fcp response
// depends on ftfe_pkg
`timescale 1ns / 1ps

module ftfe_step
    import ftfe_pkg::*;
(
    input  state_t st,
    input  in_t    din,
    output state_t st_next,
    output out_t   res
);

    state_t     nx;
    out_t       r;
    logic [7:0] cont_dec;
    logic [7:0] out_dec;
    logic [7:0] inn_dec;
    logic [3:0] ocode;
    logic [3:0] icode;
    logic [7:0] b;

    assign b        = din.in_byte;
    assign cont_dec = st.container_remaining - 8'd1;
    assign out_dec  = st.outer_remaining - 8'd1;
    assign inn_dec  = st.inner_remaining - 8'd1;
    assign ocode    = outer_code(st.outer_tag);
    assign icode    = inner_code(st.inner_tag, st.key_file_flag);

    always_comb
    begin
        nx = st;
        r  = '0;
        if (!st.nested_level)
        begin
            unique case (st.outer_phase)
                PH_TAG:
                begin
                    nx.outer_tag   = b;
                    nx.outer_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    priority if (st.outer_tag == TAG_TEMPLATE)
                    begin
                        nx.outer_phase = PH_TAG;
                    end
                    else if (st.outer_tag == TAG_CONTAINER)
                    begin
                        nx.container_remaining = b;
                        nx.outer_phase         = PH_TAG;
                        if (b != 8'd0)
                        begin
                            nx.nested_level = 1'b1;
                            nx.inner_phase  = PH_TAG;
                        end
                    end
                    else
                    begin
                        if (st.outer_tag == TAG_FILE_TYPE && b == 8'd0)
                        begin
                            nx.key_file_flag = 1'b0;
                        end
                        nx.outer_remaining = b;
                        nx.value_position  = 8'd0;
                        nx.outer_phase     = (b != 8'd0) ? PH_VAL : PH_TAG;
                    end
                end
                PH_VAL:
                begin
                    if (st.outer_tag == TAG_FILE_TYPE && st.value_position == 8'd0)
                    begin
                        nx.key_file_flag = (b == FT_KEY_A) || (b == FT_KEY_B);
                    end
                    if (ocode != NO_CODE)
                    begin
                        r.emit       = 1'b1;
                        r.field_code = ocode;
                        r.byte_index = st.value_position;
                        r.value_byte = b;
                    end
                    nx.value_position  = st.value_position + 8'd1;
                    nx.outer_remaining = out_dec;
                    if (out_dec == 8'd0)
                    begin
                        r.value_end    = r.emit;
                        nx.outer_phase = PH_TAG;
                    end
                end
                default:
                begin
                    nx.outer_phase = PH_TAG;
                end
            endcase
        end
        else
        begin
            nx.container_remaining = cont_dec;
            unique case (st.inner_phase)
                PH_TAG:
                begin
                    nx.inner_tag   = b;
                    nx.inner_phase = PH_LEN;
                    if (cont_dec == 8'd0)
                    begin
                        r.truncated     = 1'b1;
                        nx.nested_level = 1'b0;
                        nx.inner_phase  = PH_TAG;
                        nx.outer_phase  = PH_TAG;
                    end
                end
                PH_LEN:
                begin
                    nx.inner_remaining = b;
                    nx.value_position  = 8'd0;
                    priority if (b == 8'd0)
                    begin
                        nx.inner_phase = PH_TAG;
                        if (cont_dec == 8'd0)
                        begin
                            nx.nested_level = 1'b0;
                            nx.outer_phase  = PH_TAG;
                        end
                    end
                    else if (cont_dec == 8'd0)
                    begin
                        r.truncated     = 1'b1;
                        nx.nested_level = 1'b0;
                        nx.inner_phase  = PH_TAG;
                        nx.outer_phase  = PH_TAG;
                    end
                    else
                    begin
                        nx.inner_phase = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    if (icode != NO_CODE)
                    begin
                        r.emit       = 1'b1;
                        r.field_code = icode;
                        r.byte_index = st.value_position;
                        r.value_byte = b;
                    end
                    nx.value_position  = st.value_position + 8'd1;
                    nx.inner_remaining = inn_dec;
                    priority if (inn_dec == 8'd0)
                    begin
                        r.value_end    = r.emit;
                        nx.inner_phase = PH_TAG;
                        if (cont_dec == 8'd0)
                        begin
                            nx.nested_level = 1'b0;
                            nx.outer_phase  = PH_TAG;
                        end
                    end
                    else if (cont_dec == 8'd0)
                    begin
                        r.value_end     = r.emit;
                        r.truncated     = 1'b1;
                        nx.nested_level = 1'b0;
                        nx.inner_phase  = PH_TAG;
                        nx.outer_phase  = PH_TAG;
                    end
                    else
                    begin
                        nx.inner_phase = PH_VAL;
                    end
                end
                default:
                begin
                    nx.inner_phase = PH_TAG;
                end
            endcase
        end

        r.key_file  = nx.key_file_flag;
        r.frame_end = din.frame_last;
        if (din.frame_last)
        begin
            if (nx.nested_level || nx.outer_phase != PH_TAG)
            begin
                r.truncated = 1'b1;
            end
            nx = STATE_RESET;
        end
    end

    assign st_next = nx;
    assign res     = r;

endmodule

[sv/fcp_tlv_field_extractor_core.sv]
// top level of the fcp tlv field extractor: input register, parse state, result register
// depends on ftfe_pkg and ftfe_step
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_ready  | in_data  (in_byte, frame_last)
//  out     | out_valid / out_ready| out_data (emit ... truncated)
//
// one byte per cycle sustained while out_ready holds; a byte passes the input register, then the result register
// the parse state updates when a registered byte moves into the result register
// reset returns the parser to the outer level expecting a tag, both stages empty
// a stalled result holds its register; the input register still takes one byte,
// then in_ready follows out_ready

module fcp_tlv_field_extractor_core
    import ftfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic   in_valid_reg;
    logic   in_valid_next;
    in_t    in_data_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    out_t   out_data_reg;
    state_t state_reg;
    state_t state_next;
    state_t step_state;
    out_t   step_res;
    logic   out_free;
    logic   fire;
    logic   in_xfer;

    ftfe_step u_step
    (
        .st      (state_reg),
        .din     (in_data_reg),
        .st_next (step_state),
        .res     (step_res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next  = in_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        state_next     = fire ? step_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // quiet result fields when nothing is emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.emit |->
            out_data.field_code == 4'd0 && out_data.byte_index == 8'd0 &&
            out_data.value_byte == 8'd0 && !out_data.value_end)
    else $error("non-emit result carries field data");

    // value_end only marks an emitted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.value_end |-> out_data.emit)
    else $error("value_end without emit");

    // frame end returns the parser to reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_data_reg.frame_last |=> state_reg == STATE_RESET)
    else $error("state not cleared after frame end");

    // every processed byte lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg && out_data_reg.frame_end == $past(in_data_reg.frame_last))
    else $error("result transfer lost");
`endif

endmodule

[verif/tb_fcp_tlv_field_extractor_core.sv]
// self-checking testbench for fcp_tlv_field_extractor_core: directed and random fcp frames
// depends on ftfe_pkg and the core rtl; holds its own byte-level parser for expected results
`timescale 1ns / 1ps

module tb_fcp_tlv_field_extractor_core;
    import ftfe_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    in_t        byte_queue[$];
    out_t       expected_results[$];
    logic [7:0] frame_buf[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int queued_items = 0;

    // parser state
    logic       at_nested = 1'b0;
    phase_t     top_phase = PH_TAG;
    phase_t     sub_phase = PH_TAG;
    logic [7:0] top_tag = '0;
    logic [7:0] top_left = '0;
    logic [7:0] sub_tag = '0;
    logic [7:0] sub_left = '0;
    logic [7:0] box_left = '0;
    logic [7:0] pos = '0;
    logic       kf_flag = 1'b0;

    fcp_tlv_field_extractor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [3:0] top_field(input logic [7:0] tag);
        case (tag)
            8'h80:   return CODE_O80;
            8'h82:   return CODE_O82;
            8'h83:   return CODE_O83;
            8'h84:   return CODE_O84;
            8'h88:   return CODE_O88;
            8'h8A:   return CODE_O8A;
            8'h8B:   return CODE_O8B;
            default: return NO_CODE;
        endcase
    endfunction

    function automatic logic [3:0] sub_field(input logic [7:0] tag, input logic key);
        if (!key)
        begin
            return (tag == 8'h81) ? CODE_N81 : NO_CODE;
        end
        case (tag)
            8'h85:   return CODE_K85;
            8'h86:   return CODE_K86;
            8'h87:   return CODE_K87;
            8'h89:   return CODE_K89;
            8'h8B:   return CODE_K8B;
            8'h8E:   return CODE_K8E;
            default: return NO_CODE;
        endcase
    endfunction

    function automatic void close_box();
        at_nested = 1'b0;
        sub_phase = PH_TAG;
        top_phase = PH_TAG;
    endfunction

    function automatic void clear_parser();
        close_box();
        top_tag = '0;
        top_left = '0;
        sub_tag = '0;
        sub_left = '0;
        box_left = '0;
        pos = '0;
        kf_flag = 1'b0;
    endfunction

    function automatic out_t extract_fields(input in_t item);
        out_t       r;
        logic [3:0] c;
        logic [7:0] b;
        r = '0;
        b = item.in_byte;
        if (!at_nested)
        begin
            case (top_phase)
                PH_TAG:
                begin
                    top_tag = b;
                    top_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    if (top_tag == TAG_TEMPLATE)
                    begin
                        top_phase = PH_TAG;
                    end
                    else if (top_tag == TAG_CONTAINER)
                    begin
                        box_left = b;
                        top_phase = PH_TAG;
                        if (b != 0)
                        begin
                            at_nested = 1'b1;
                            sub_phase = PH_TAG;
                        end
                    end
                    else
                    begin
                        if (top_tag == TAG_FILE_TYPE && b == 0)
                            kf_flag = 1'b0;
                        top_left = b;
                        pos = '0;
                        top_phase = (b != 0) ? PH_VAL : PH_TAG;
                    end
                end
                default:
                begin
                    if (top_tag == TAG_FILE_TYPE && pos == 0)
                        kf_flag = (b == FT_KEY_A || b == FT_KEY_B);
                    c = top_field(top_tag);
                    if (c != NO_CODE)
                    begin
                        r.emit = 1'b1;
                        r.field_code = c;
                        r.byte_index = pos;
                        r.value_byte = b;
                    end
                    pos = pos + 8'd1;
                    top_left = top_left - 8'd1;
                    if (top_left == 0)
                    begin
                        r.value_end = r.emit;
                        top_phase = PH_TAG;
                    end
                end
            endcase
        end
        else
        begin
            box_left = box_left - 8'd1;
            case (sub_phase)
                PH_TAG:
                begin
                    sub_tag = b;
                    sub_phase = PH_LEN;
                    if (box_left == 0)
                    begin
                        r.truncated = 1'b1;
                        close_box();
                    end
                end
                PH_LEN:
                begin
                    sub_left = b;
                    pos = '0;
                    if (b == 0)
                    begin
                        sub_phase = PH_TAG;
                        if (box_left == 0)
                            close_box();
                    end
                    else if (box_left == 0)
                    begin
                        r.truncated = 1'b1;
                        close_box();
                    end
                    else
                    begin
                        sub_phase = PH_VAL;
                    end
                end
                default:
                begin
                    c = sub_field(sub_tag, kf_flag);
                    if (c != NO_CODE)
                    begin
                        r.emit = 1'b1;
                        r.field_code = c;
                        r.byte_index = pos;
                        r.value_byte = b;
                    end
                    pos = pos + 8'd1;
                    sub_left = sub_left - 8'd1;
                    if (sub_left == 0)
                    begin
                        r.value_end = r.emit;
                        sub_phase = PH_TAG;
                        if (box_left == 0)
                            close_box();
                    end
                    else if (box_left == 0)
                    begin
                        r.value_end = r.emit;
                        r.truncated = 1'b1;
                        close_box();
                    end
                end
            endcase
        end
        r.key_file = kf_flag;
        r.frame_end = item.frame_last;
        if (item.frame_last)
        begin
            if (at_nested || top_phase != PH_TAG)
                r.truncated = 1'b1;
            clear_parser();
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic check_result(input out_t act);
        out_t exp_r;
        if (expected_results.size() == 0)
        begin
            $error("result transfer with no expected result pending");
            error_count++;
        end
        else
        begin
            exp_r = expected_results.pop_front();
            compare_field("emit", exp_r.emit, act.emit);
            compare_field("field_code", exp_r.field_code, act.field_code);
            compare_field("byte_index", exp_r.byte_index, act.byte_index);
            compare_field("value_byte", exp_r.value_byte, act.value_byte);
            compare_field("value_end", exp_r.value_end, act.value_end);
            compare_field("key_file", exp_r.key_file, act.key_file);
            compare_field("frame_end", exp_r.frame_end, act.frame_end);
            compare_field("truncated", exp_r.truncated, act.truncated);
        end
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(extract_fields(in_data));
            if (!in_valid || in_ready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= byte_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                results_seen++;
                if (results_seen == 60 || results_seen == 360)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] pick_outer_tag();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h82;
            2:       return 8'h83;
            3:       return 8'h84;
            4:       return 8'h88;
            5:       return 8'h8A;
            6:       return 8'h8B;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_inner_tag();
        case ($urandom_range(0, 8))
            0:       return 8'h85;
            1:       return 8'h86;
            2:       return 8'h87;
            3:       return 8'h89;
            4:       return 8'h8B;
            5:       return 8'h8E;
            6:       return 8'h81;
            7:       return TAG_TEMPLATE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 4);
    endfunction

    task automatic add_tlv(input logic [7:0] tag, input int len);
        frame_buf.push_back(tag);
        frame_buf.push_back(8'(len));
        repeat (len) frame_buf.push_back(8'($urandom));
    endtask

    task automatic send_frame();
        in_t item;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            item.in_byte = frame_buf[i];
            item.frame_last = (i == frame_buf.size() - 1);
            byte_queue.push_back(item);
        end
        queued_items += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic random_frame();
        int len_idx;
        int start;
        int total;
        int keep;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) frame_buf.push_back(8'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 1))
            begin
                frame_buf.push_back(TAG_TEMPLATE);
                frame_buf.push_back(8'($urandom));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                frame_buf.push_back(TAG_FILE_TYPE);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        frame_buf.push_back(8'd1);
                        frame_buf.push_back(FT_KEY_A);
                    end
                    1:
                    begin
                        frame_buf.push_back(8'd2);
                        frame_buf.push_back(FT_KEY_B);
                        frame_buf.push_back(8'($urandom));
                    end
                    2:
                    begin
                        frame_buf.push_back(8'd1);
                        frame_buf.push_back(8'($urandom));
                    end
                    default: frame_buf.push_back(8'd0);
                endcase
            end
            repeat ($urandom_range(0, 2)) add_tlv(pick_outer_tag(), pick_len());
            if ($urandom_range(0, 9) < 7)
            begin
                frame_buf.push_back(TAG_CONTAINER);
                len_idx = frame_buf.size();
                frame_buf.push_back(8'd0);
                start = frame_buf.size();
                repeat ($urandom_range(0, 3)) add_tlv(pick_inner_tag(), pick_len());
                total = frame_buf.size() - start;
                case ($urandom_range(0, 9))
                    0:       if (total > 0) total = $urandom_range(1, total);
                    1:       total = total + $urandom_range(1, 3);
                    default: ;
                endcase
                frame_buf[len_idx] = 8'((total > 255) ? 255 : total);
            end
            repeat ($urandom_range(0, 1)) add_tlv(pick_outer_tag(), pick_len());
            if (frame_buf.size() == 0)
                frame_buf.push_back(8'($urandom));
            if ($urandom_range(0, 9) == 0)
            begin
                keep = $urandom_range(1, frame_buf.size());
                while (frame_buf.size() > keep)
                    void'(frame_buf.pop_back());
            end
        end
        send_frame();
    endtask

    task automatic drain_pipeline();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    initial
    begin
        send_idle_pct = 6;
        recv_idle_pct = 77;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // key file set, container ends exactly, extreme bytes
        frame_buf = '{8'h62, 8'hFF, 8'h82, 8'h01, 8'h11, 8'hA5, 8'h03, 8'h8E, 8'h01, 8'hFF};
        send_frame();
        // empty file type value, empty container
        frame_buf = '{8'h82, 8'h00, 8'hA5, 8'h00, 8'h8B, 8'h01, 8'h00};
        send_frame();
        // nested length runs past the container
        frame_buf = '{8'hA5, 8'h02, 8'h81, 8'h05};
        send_frame();
        // nested template skipped, frame ends inside a value
        frame_buf = '{8'hA5, 8'h03, 8'h62, 8'h01, 8'h7F, 8'h84, 8'h02, 8'h01};
        send_frame();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            queued_items = 0;
            while (queued_items < PHASE_ITEMS)
                random_frame();
            drain_pipeline();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
